[rtl/core/kma_pkg.sv]
// Shared types, constants and the key translation ROM of the key matrix encoder.
package kma_pkg;

	localparam int unsigned TABLE_ENTRIES = 70;
	localparam int unsigned MATRIX_COLS   = 10;
	localparam int unsigned IX_W          = $clog2(TABLE_ENTRIES);

	// Tab code after reset
	localparam logic [7:0] TAB_CODE_RESET = 8'h09;

	// Translation ROM, row-major, 10 columns per row
	localparam logic [7:0] KEY_ROM [TABLE_ENTRIES] = '{
		8'h71, 8'h33, 8'h34, 8'h35, 8'h84, 8'h38, 8'h87, 8'h2D, 8'h5E, 8'h8C,
		8'h80, 8'h77, 8'h65, 8'h74, 8'h37, 8'h69, 8'h39, 8'h30, 8'h5F, 8'h8E,
		8'h31, 8'h32, 8'h64, 8'h72, 8'h36, 8'h75, 8'h6F, 8'h70, 8'h5B, 8'h8F,
		8'h01, 8'h61, 8'h78, 8'h66, 8'h79, 8'h6A, 8'h6B, 8'h40, 8'h3A, 8'h0D,
		8'h02, 8'h73, 8'h63, 8'h67, 8'h68, 8'h6E, 8'h6C, 8'h3B, 8'h5D, 8'h7F,
		8'h00, 8'h7A, 8'h20, 8'h76, 8'h62, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h8B,
		8'h1B, 8'h81, 8'h82, 8'h83, 8'h85, 8'h86, 8'h88, 8'h89, 8'h5C, 8'h8D
	};

	// One input beat
	typedef struct packed {
		logic [6:0] key_number;
		logic       ctrl_down;
		logic       shift_down;
		logic       shift_enable;
		logic       shift_lock_active;
		logic       caps_lock_active;
		logic       second_key_held;
	} key_item_t;

	// ROM lookup result
	typedef struct packed {
		logic [7:0] code;
		logic       invalid;
	} lookup_t;

	// One result beat
	typedef struct packed {
		logic [7:0] char_code;
		logic       printable;
		logic       cancelled;
		logic       invalid_key;
	} result_t;

endpackage

[rtl/core/key_matrix_to_ascii_unit.sv]
// Top level of the key matrix to character code encoder.
//
// Input channel (in_valid/in_ready): one beat per key event, carrying the key
// number and the modifier state. Output channel (out_valid/out_ready): one
// result beat per input beat, in order, with the character code, a printable
// flag, a rollover cancel flag and an invalid key flag.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the tab code;
// it is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. Two register stages: an input
// register, then ROM lookup and modifier folding into the result register.
// A result passes the input register, then the result register. Throughput
// is one beat per cycle while the receiver keeps out_ready high.
// When the receiver stalls, the result register holds and the input register
// keeps accepting until it too is full; in_ready then follows out_ready.
// Reset clears both stage valids and restores the tab code to 0x09.
module key_matrix_to_ascii_unit (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [6:0] key_number,
	input  logic       ctrl_down,
	input  logic       shift_down,
	input  logic       shift_enable,
	input  logic       shift_lock_active,
	input  logic       caps_lock_active,
	input  logic       second_key_held,
	// output channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_code,
	output logic       printable,
	output logic       cancelled,
	output logic       invalid_key
);

	logic [7:0]         tab_q;
	logic               valid_s1;
	logic               valid_s2;
	kma_pkg::key_item_t item_s1;
	kma_pkg::lookup_t   lookup;
	kma_pkg::result_t   result;
	kma_pkg::result_t   result_s2;
	logic               adv_s2;

	// Tab code register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q <= kma_pkg::TAB_CODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tab_q <= cfg_data;
		end
	end

	// Handshake: result register frees up or is empty
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	// Stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.key_number        <= key_number;
			item_s1.ctrl_down         <= ctrl_down;
			item_s1.shift_down        <= shift_down;
			item_s1.shift_enable      <= shift_enable;
			item_s1.shift_lock_active <= shift_lock_active;
			item_s1.caps_lock_active  <= caps_lock_active;
			item_s1.second_key_held   <= second_key_held;
		end
	end

	// Lookup and modifier folding
	kma_lookup u_lookup (
		.key_number (item_s1.key_number),
		.tab_code   (tab_q),
		.lookup     (lookup)
	);

	kma_fold u_fold (
		.item   (item_s1),
		.lookup (lookup),
		.result (result)
	);

	// Stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign char_code   = result_s2.char_code;
	assign printable   = result_s2.printable;
	assign cancelled   = result_s2.cancelled;
	assign invalid_key = result_s2.invalid_key;

endmodule

[rtl/core/kma_lookup.sv]
// Key number range check and translation ROM lookup.
module kma_lookup (
	input  logic [6:0]       key_number,
	input  logic [7:0]       tab_code,
	output kma_pkg::lookup_t lookup
);

	logic [2:0]              row;
	logic [3:0]              col;
	logic [2:0]              row_m1;
	logic [6:0]              ix_full;
	logic [kma_pkg::IX_W-1:0] rom_ix;
	logic                    invalid;
	logic [7:0]              rom_code;

	// Split the key number and flag keys outside the matrix
	assign row     = key_number[6:4];
	assign col     = key_number[3:0];
	assign invalid = (row == 3'd0) || (col >= 4'(kma_pkg::MATRIX_COLS));

	// Index = (row - 1) * 10 + col, as two shifts and adds
	assign row_m1  = row - 3'd1;
	assign ix_full = {1'b0, row_m1, 3'b000} + {3'b000, row_m1, 1'b0} + {3'b000, col};
	assign rom_ix  = invalid ? '0 : ix_full[kma_pkg::IX_W-1:0];

	assign rom_code = kma_pkg::KEY_ROM[rom_ix];

	// Zero entry stands for the configured tab code
	always_comb begin
		lookup.invalid = invalid;
		lookup.code    = (rom_code == 8'h00) ? tab_code : rom_code;
	end

endmodule

[rtl/core/kma_fold.sv]
// Modifier chain: control folding, shift lock, caps lock, shift key.
module kma_fold (
	input  kma_pkg::key_item_t item,
	input  kma_pkg::lookup_t   lookup,
	output kma_pkg::result_t   result
);

	localparam logic [7:0] XOR_COMMON  = 8'h30;
	localparam logic [7:0] SWAP_A      = 8'h6F;
	localparam logic [7:0] SWAP_B      = 8'h50;
	localparam logic [7:0] XOR_SWAP    = 8'h1F;
	localparam logic [7:0] PUNCT_LOW   = 8'h21;
	localparam logic [7:0] XOR_CASE    = 8'h10;
	localparam logic [7:0] CTRL_GRAVE  = 8'h60;
	localparam logic [7:0] CTRL_UNDER  = 8'h5F;
	localparam logic [7:0] CHAR_AT     = 8'h40;
	localparam logic [7:0] CHAR_DEL    = 8'h7F;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TOP    = 8'h80;
	localparam logic [7:0] CTRL_MASK   = 8'h1F;

	function automatic logic [7:0] fold_common(input logic [7:0] c);
		logic [7:0] t;
		t = c ^ XOR_COMMON;
		if (t == SWAP_A || t == SWAP_B) t = t ^ XOR_SWAP;
		if (t >= PUNCT_LOW) t = t ^ XOR_CASE;
		return t;
	endfunction

	function automatic logic [7:0] fold_shift(input logic [7:0] c);
		logic [7:0] t;
		t = c;
		priority if (c == CHAR_SPACE || c == CHAR_AT || c == CHAR_DEL) begin
			t = c;
		end else if (c < CHAR_AT) begin
			t = (c >= PUNCT_LOW) ? (c ^ XOR_CASE) : c;
		end else if (c > CHAR_DEL) begin
			t = c ^ XOR_CASE;
		end else begin
			t = fold_common(c);
		end
		return t;
	endfunction

	function automatic logic [7:0] fold_ctrl(input logic [7:0] c);
		logic [7:0] t;
		if (c == CHAR_DEL) begin
			t = c;
		end else begin
			t = fold_common(c);
			if (t == CTRL_GRAVE) t = CTRL_UNDER;
			else if (t >= CHAR_AT) t = t & CTRL_MASK;
		end
		return t;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	logic [7:0] a_ctrl;
	logic [7:0] a_lock;
	logic [7:0] a_shift;
	logic       caps_skipped;
	logic       shift_apply;

	// Control stage
	assign a_ctrl = item.ctrl_down ? fold_ctrl(lookup.code) : lookup.code;

	// Shift lock wins over caps lock; caps lock touches letters only
	always_comb begin
		caps_skipped = 1'b0;
		priority if (item.shift_lock_active) begin
			a_lock = fold_shift(a_ctrl);
		end else if (item.caps_lock_active) begin
			if (is_letter(a_ctrl)) begin
				a_lock = fold_shift(a_ctrl);
			end else begin
				a_lock       = a_ctrl;
				caps_skipped = 1'b1;
			end
		end else begin
			a_lock = a_ctrl;
		end
	end

	// Shift key stage
	assign shift_apply = item.shift_down && (caps_skipped || item.shift_enable);
	assign a_shift     = shift_apply ? fold_shift(a_lock) : a_lock;

	// Final result with invalid and rollover cancel cases
	always_comb begin
		result = '0;
		priority if (lookup.invalid) begin
			result.invalid_key = 1'b1;
		end else if (item.second_key_held && (item.ctrl_down || shift_apply)) begin
			result.cancelled = 1'b1;
		end else begin
			result.char_code = a_shift;
			result.printable = (a_shift > CHAR_SPACE) && (a_shift < CHAR_TOP);
		end
	end

endmodule
